[design/pmfb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmfb_pkg
// Shared types and fixed constants for the page mode monochrome frame store.
// ----------------------------------------------------------------------------
package pmfb_pkg;

    // One page is eight rows tall, and each page byte holds one column of it.
    localparam int BYTE_W     = 8;
    localparam int PAGE_ROWS  = 8;
    localparam int PAGE_SHIFT = 3;

    localparam logic [7:0] DRAW_HEIGHT_RESET = 8'd56;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [2:0] {
        MODE_PIXEL_WRITE = 3'd0,
        MODE_PIXEL_READ  = 3'd1,
        MODE_BYTE_WRITE  = 3'd2,
        MODE_BYTE_READ   = 3'd3,
        MODE_CLEAR       = 3'd4,
        MODE_INVERT      = 3'd5,
        MODE_RECT_FILL   = 3'd6
    } mode_t;

endpackage
`default_nettype wire

[design/pmfb_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmfb_ram
// Frame store memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module pmfb_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire pmfb_pkg::byte_t     wr_data,
    input  wire logic                rd_en,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output pmfb_pkg::byte_t          rd_data
);

    pmfb_pkg::byte_t mem [DEPTH];
    pmfb_pkg::byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[design/page_mode_mono_framebuffer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// page_mode_mono_framebuffer_unit
// Monochrome frame store in 8-row pages with pixel, byte and block commands.
// ----------------------------------------------------------------------------
// Usage:
// A command transfer happens on a rising edge with start high and busy low.
// The block then holds busy high until the command is finished. Each command
// returns exactly one result, shown on pixel_value, byte_value and in_range
// for a single cycle while done is high; the receiver cannot stall it, so
// it must take the result in that cycle. busy is already low during that
// cycle, so the next command may be issued alongside the result.
// Byte write, unused mode and any command that is out of range or clipped
// end in the decode state. Pixel write, pixel read and byte read in range do
// one memory read, then a write or the result. Clear writes zero over the
// whole store; invert passes over every byte of it; rect fill passes over its
// columns in each touched page, and ends in decode when it is empty. The
// block commands handle the store memory one byte per cycle.
// After reset the block sweeps all STORE_BYTES bytes (1024 at the default
// size) to zero, one byte per cycle, with busy high. The
// draw height register is written through cfg_valid and cfg_ready, which is
// always high; writes belong between commands, with nothing in flight.
// ----------------------------------------------------------------------------
module page_mode_mono_framebuffer_unit #(
    parameter int SCREEN_W = 128,
    parameter int SCREEN_H = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Command channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         mode,
    input  wire logic signed [15:0] x,
    input  wire logic signed [15:0] y,
    input  wire logic               color,
    input  wire logic               clip_render,
    input  wire logic [7:0]         data_byte,
    input  wire logic [7:0]         rect_width,
    input  wire logic [7:0]         rect_height,
    // Result channel
    output logic                    done,
    output logic                    pixel_value,
    output logic [7:0]              byte_value,
    output logic                    in_range,
    // Configuration channel (draw height)
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_data
);

    // Store geometry, all derived from the screen size.
    localparam int PAGE_COUNT  = (SCREEN_H + pmfb_pkg::PAGE_ROWS - 1) / pmfb_pkg::PAGE_ROWS;
    localparam int STORE_BYTES = SCREEN_W * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COL_W       = $clog2(SCREEN_W);
    localparam int ROW_W       = $clog2(SCREEN_H);
    localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
    localparam logic signed [17:0] W_S       = 18'(SCREEN_W);
    localparam logic signed [17:0] H_S       = 18'(SCREEN_H);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_CLEAR,
        S_RMW
    } state_t;

    // Control registers.
    state_t              state_reg, state_next;
    logic                done_reg, done_next;
    logic [7:0]          draw_height_reg;
    logic [ADDR_W-1:0]   addr_reg, addr_next;

    // Command and sweep payload registers.
    pmfb_pkg::mode_t     mode_reg;
    logic signed [15:0]  x_reg, y_reg;
    logic                color_reg, clip_reg;
    logic [7:0]          data_reg, w_reg, h_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [COL_W-1:0]    col_lo_reg, col_lo_next;
    logic [COL_W-1:0]    col_hi_reg, col_hi_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [PAGE_W-1:0]   page_lo_reg, page_lo_next;
    logic [PAGE_W-1:0]   page_hi_reg, page_hi_next;
    logic [2:0]          row_lo_reg, row_lo_next;
    logic [2:0]          row_hi_reg, row_hi_next;
    pmfb_pkg::byte_t     mask_reg, mask_next;
    logic                pixel_value_reg, pixel_value_next;
    pmfb_pkg::byte_t     byte_value_reg, byte_value_next;
    logic                in_range_reg, in_range_next;

    // Memory ports.
    logic                wr_en, rd_en;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;
    pmfb_pkg::byte_t     wr_data, rd_data;

    // Decode terms.
    logic signed [17:0]  xs, ys, xe, ye, x0, y0, x1, y1, x_last, y_last;
    logic signed [17:0]  rh_s;
    logic                x_on, y_on, render_ok, rect_empty;
    logic [ROW_W-1:0]    row_sel, row_first, row_final;
    logic [ADDR_W-1:0]   single_addr;
    pmfb_pkg::byte_t     rect_mask;
    logic [2:0]          mask_lo, mask_hi;

    function automatic logic [PAGE_W-1:0] row_to_page(input logic [ROW_W-1:0] row);
        logic [ROW_W-1:0] shifted;
        shifted = row >> pmfb_pkg::PAGE_SHIFT;
        return shifted[PAGE_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [PAGE_W-1:0] page,
                                                     input logic [COL_W-1:0]  col);
        return ADDR_W'(page * SCREEN_W + col);
    endfunction

    pmfb_ram #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign pixel_value = pixel_value_reg;
    assign byte_value  = byte_value_reg;
    assign in_range    = in_range_reg;

    // Bounds of the latched command. Coordinates are widened to 18 bits so
    // that the rectangle's far edge never wraps.
    always_comb
    begin
        xs        = 18'(x_reg);
        ys        = 18'(y_reg);
        rh_s      = $signed({10'd0, draw_height_reg});
        x_on      = (xs >= 18'sd0) && (xs < W_S);
        y_on      = (ys >= 18'sd0) && (ys < H_S);
        render_ok = !clip_reg || (ys < rh_s);
        row_sel   = ys[ROW_W-1:0];
        single_addr = store_addr(row_to_page(row_sel), xs[COL_W-1:0]);

        xe     = xs + $signed({10'd0, w_reg});
        ye     = ys + $signed({10'd0, h_reg});
        x0     = (xs < 18'sd0) ? 18'sd0 : xs;
        y0     = (ys < 18'sd0) ? 18'sd0 : ys;
        x1     = (xe > W_S) ? W_S : xe;
        y1     = (ye > H_S) ? H_S : ye;
        x_last = x1 - 18'sd1;
        y_last = y1 - 18'sd1;
        rect_empty = (x0 >= x1) || (y0 >= y1);
        row_first  = y0[ROW_W-1:0];
        row_final  = y_last[ROW_W-1:0];
    end

    // Rows of the current page that the rectangle covers.
    always_comb
    begin
        mask_lo = (page_reg == page_lo_reg) ? row_lo_reg : 3'd0;
        mask_hi = (page_reg == page_hi_reg) ? row_hi_reg : 3'd7;
        for (int i = 0; i < pmfb_pkg::BYTE_W; i++)
        begin
            rect_mask[i] = (3'(i) >= mask_lo) && (3'(i) <= mask_hi);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        done_next        = 1'b0;
        addr_next        = addr_reg;
        col_next         = col_reg;
        page_next        = page_reg;
        col_lo_next      = col_lo_reg;
        col_hi_next      = col_hi_reg;
        page_lo_next     = page_lo_reg;
        page_hi_next     = page_hi_reg;
        row_lo_next      = row_lo_reg;
        row_hi_next      = row_hi_reg;
        mask_next        = mask_reg;
        pixel_value_next = pixel_value_reg;
        byte_value_next  = byte_value_reg;
        in_range_next    = in_range_reg;
        wr_en            = 1'b0;
        wr_addr          = addr_reg;
        wr_data          = '0;
        rd_en            = 1'b0;
        rd_addr          = addr_reg;

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_data = '0;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                    if (state_reg == S_CLEAR)
                    begin
                        done_next        = 1'b1;
                        pixel_value_next = 1'b0;
                        byte_value_next  = '0;
                        in_range_next    = 1'b0;
                    end
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                // Unless a memory pass follows, the command ends here.
                state_next       = S_IDLE;
                done_next        = 1'b1;
                pixel_value_next = 1'b0;
                byte_value_next  = '0;
                in_range_next    = 1'b0;
                addr_next        = single_addr;
                mask_next        = pmfb_pkg::byte_t'(1) << ys[2:0];
                case (mode_reg)
                    pmfb_pkg::MODE_PIXEL_WRITE:
                    begin
                        if (x_on && y_on && render_ok)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = single_addr;
                            state_next = S_RMW;
                            done_next  = 1'b0;
                        end
                    end
                    pmfb_pkg::MODE_PIXEL_READ, pmfb_pkg::MODE_BYTE_READ:
                    begin
                        if (x_on && y_on)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = single_addr;
                            state_next = S_RMW;
                            done_next  = 1'b0;
                        end
                    end
                    pmfb_pkg::MODE_BYTE_WRITE:
                    begin
                        if (x_on && y_on)
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = single_addr;
                            wr_data       = data_reg;
                            in_range_next = 1'b1;
                        end
                    end
                    pmfb_pkg::MODE_CLEAR:
                    begin
                        addr_next  = '0;
                        state_next = S_CLEAR;
                        done_next  = 1'b0;
                    end
                    pmfb_pkg::MODE_INVERT:
                    begin
                        addr_next  = '0;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_RMW;
                        done_next  = 1'b0;
                    end
                    pmfb_pkg::MODE_RECT_FILL:
                    begin
                        if (!rect_empty)
                        begin
                            col_lo_next  = x0[COL_W-1:0];
                            col_hi_next  = x_last[COL_W-1:0];
                            page_lo_next = row_to_page(row_first);
                            page_hi_next = row_to_page(row_final);
                            row_lo_next  = y0[2:0];
                            row_hi_next  = y_last[2:0];
                            col_next     = x0[COL_W-1:0];
                            page_next    = row_to_page(row_first);
                            addr_next    = store_addr(row_to_page(row_first), x0[COL_W-1:0]);
                            rd_en        = 1'b1;
                            rd_addr      = addr_next;
                            state_next   = S_RMW;
                            done_next    = 1'b0;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_RMW:
            begin
                // The byte at addr_reg is on rd_data. Block commands write it
                // back and fetch the next byte in the same cycle.
                case (mode_reg)
                    pmfb_pkg::MODE_PIXEL_WRITE:
                    begin
                        wr_en            = 1'b1;
                        wr_data          = color_reg ? (rd_data | mask_reg)
                                                     : (rd_data & ~mask_reg);
                        state_next       = S_IDLE;
                        done_next        = 1'b1;
                        in_range_next    = 1'b1;
                    end
                    pmfb_pkg::MODE_PIXEL_READ:
                    begin
                        pixel_value_next = rd_data[y_reg[2:0]];
                        state_next       = S_IDLE;
                        done_next        = 1'b1;
                        in_range_next    = 1'b1;
                    end
                    pmfb_pkg::MODE_BYTE_READ:
                    begin
                        byte_value_next  = rd_data;
                        state_next       = S_IDLE;
                        done_next        = 1'b1;
                        in_range_next    = 1'b1;
                    end
                    pmfb_pkg::MODE_INVERT:
                    begin
                        wr_en   = 1'b1;
                        wr_data = ~rd_data;
                        if (addr_reg == LAST_ADDR)
                        begin
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            addr_next = addr_reg + 1'b1;
                            rd_en     = 1'b1;
                            rd_addr   = addr_next;
                        end
                    end
                    pmfb_pkg::MODE_RECT_FILL:
                    begin
                        wr_en   = 1'b1;
                        wr_data = color_reg ? (rd_data | rect_mask)
                                            : (rd_data & ~rect_mask);
                        if (col_reg == col_hi_reg)
                        begin
                            if (page_reg == page_hi_reg)
                            begin
                                state_next = S_IDLE;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                page_next = page_reg + 1'b1;
                                col_next  = col_lo_reg;
                            end
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                        if (!done_next)
                        begin
                            addr_next = store_addr(page_next, col_next);
                            rd_en     = 1'b1;
                            rd_addr   = addr_next;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            done_reg        <= 1'b0;
            addr_reg        <= '0;
            draw_height_reg <= pmfb_pkg::DRAW_HEIGHT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            addr_reg  <= addr_next;
            if (cfg_valid && cfg_ready)
            begin
                draw_height_reg <= cfg_data;
            end
        end
    end

    // Command payload and sweep bookkeeping.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            mode_reg  <= pmfb_pkg::mode_t'(mode);
            x_reg     <= x;
            y_reg     <= y;
            color_reg <= color;
            clip_reg  <= clip_render;
            data_reg  <= data_byte;
            w_reg     <= rect_width;
            h_reg     <= rect_height;
        end
        col_reg         <= col_next;
        page_reg        <= page_next;
        col_lo_reg      <= col_lo_next;
        col_hi_reg      <= col_hi_next;
        page_lo_reg     <= page_lo_next;
        page_hi_reg     <= page_hi_next;
        row_lo_reg      <= row_lo_next;
        row_hi_reg      <= row_hi_next;
        mask_reg        <= mask_next;
        pixel_value_reg <= pixel_value_next;
        byte_value_reg  <= byte_value_next;
        in_range_reg    <= in_range_next;
    end

endmodule
`default_nettype wire
